[rtl/mbt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbt_pkg
// Shared types and constants for the fixed-capacity bag table: request and
// result payloads, operation and status codes, and the scan result bundle.
// ----------------------------------------------------------------------------
package mbt_pkg;

  localparam int CAP      = 32;
  localparam int VAL_W    = 32;
  localparam int ADDR_W   = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int CNT_W    = $clog2(CAP + 1);
  localparam int OP_W     = 2;
  localparam int ST_W     = 2;
  localparam int LEVEL_W  = 6;
  localparam int IN_VAL_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_COUNT  = 2'd1,
    OP_ERASE  = 2'd2
  } op_t;

  typedef enum logic [ST_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0]     opcode;
    logic [IN_VAL_W-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [LEVEL_W-1:0] match_count;
    logic [LEVEL_W-1:0] fill_level;
  } out_item_t;

  // running result of one scan pass
  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] hit_idx;
    logic [CNT_W-1:0]  count;
  } scan_res_t;

endpackage
`default_nettype wire

[rtl/mbt_scan.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbt_scan
// Shared compare unit: checks one stored entry per cycle against the key while
// cmp_en is high, counts matches and keeps the index of the first match.
// ----------------------------------------------------------------------------
module mbt_scan (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      clr,
  input  wire logic                      cmp_en,
  input  wire logic [mbt_pkg::ADDR_W-1:0] cmp_idx,
  input  wire logic [mbt_pkg::VAL_W-1:0]  rdata,
  input  wire logic [mbt_pkg::VAL_W-1:0]  key,
  output mbt_pkg::scan_res_t             res
);
  import mbt_pkg::*;

  scan_res_t res_r, res_nxt;
  logic      eq;

  // single comparator shared over the whole pass
  assign eq = (rdata == key);

  always_comb begin
    res_nxt = res_r;
    if (clr) begin
      res_nxt = '0;
    end else if (cmp_en && eq) begin
      res_nxt.count = res_r.count + CNT_W'(1);
      if (!res_r.hit) begin
        res_nxt.hit     = 1'b1;
        res_nxt.hit_idx = cmp_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

[rtl/multiset_bag_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multiset_bag_table
// Fixed-capacity unordered multiset: insert, count matches, erase one match.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; every request gives
// exactly one result, shown on out_item for a single cycle with out_valid high,
// and the receiver must take it then. Insert and unused opcodes finish at once:
// the result appears the cycle after the request and busy stays low. Count and
// erase on an empty table also finish at once. Otherwise count walks the
// stored entries through one memory read port and one comparator, one entry a
// cycle, and holds busy until the walk ends; erase stops at the first match and
// then moves the last entry into the freed slot (S_MOVE_RD, then S_MOVE_WR),
// holding busy until the move is done. No new request is taken while busy.
// No clearing pass follows reset.
// ----------------------------------------------------------------------------
module multiset_bag_table (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output      logic               busy,
  input  wire mbt_pkg::in_item_t  in_item,
  output      logic               out_valid,
  output      mbt_pkg::out_item_t out_item
);
  import mbt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_SCAN    = 5'b00010,
    S_FIN     = 5'b00100,
    S_MOVE_RD = 5'b01000,
    S_MOVE_WR = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  op_t               op_r, op_nxt;
  logic [VAL_W-1:0]  key_r, key_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              issue_r, issue_nxt;
  logic              rd_v_r, rd_v_nxt;
  logic [ADDR_W-1:0] rd_idx_r, rd_idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  // storage and its ports
  logic [VAL_W-1:0]  mem [CAP];
  logic [VAL_W-1:0]  rdata_r;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [VAL_W-1:0]  wdata;
  logic [ADDR_W-1:0] raddr;

  logic              scan_clr;
  scan_res_t         scan;
  logic [ADDR_W-1:0] last_idx;
  logic [VAL_W-1:0]  in_val;

  assign last_idx = ADDR_W'(used_r - CNT_W'(1));
  assign in_val   = in_item.item_value[VAL_W-1:0];

  mbt_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (scan_clr),
    .cmp_en  (rd_v_r),
    .cmp_idx (rd_idx_r),
    .rdata   (rdata_r),
    .key     (key_r),
    .res     (scan)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    addr_nxt      = addr_r;
    issue_nxt     = issue_r;
    rd_v_nxt      = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    we            = 1'b0;
    waddr         = ADDR_W'(used_r);
    wdata         = in_val;
    raddr         = addr_r;
    scan_clr      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt                   = op_t'(in_item.opcode);
          key_nxt                  = in_val;
          out_item_nxt.status      = STAT_OK;
          out_item_nxt.match_count = '0;
          out_item_nxt.fill_level  = LEVEL_W'(used_r);
          case (op_t'(in_item.opcode))
            OP_INSERT: begin
              out_valid_nxt = 1'b1;
              if (used_r < CNT_W'(CAP)) begin
                we                      = 1'b1;
                used_nxt                = used_r + CNT_W'(1);
                out_item_nxt.fill_level = LEVEL_W'(used_nxt);
              end else begin
                out_item_nxt.status = STAT_FULL;
              end
            end
            OP_COUNT, OP_ERASE: begin
              if (used_r == '0) begin
                out_valid_nxt = 1'b1;
                if (op_t'(in_item.opcode) == OP_ERASE) begin
                  out_item_nxt.status = STAT_NOT_FOUND;
                end
              end else begin
                state_nxt = S_SCAN;
                addr_nxt  = '0;
                issue_nxt = 1'b1;
                scan_clr  = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      // one read issued and one compare done per cycle
      S_SCAN: begin
        if (issue_r) begin
          rd_v_nxt   = 1'b1;
          rd_idx_nxt = addr_r;
          if (addr_r == last_idx) begin
            issue_nxt = 1'b0;
          end else begin
            addr_nxt = addr_r + ADDR_W'(1);
          end
        end
        if ((!issue_r && !rd_v_r) || (op_r == OP_ERASE && scan.hit)) begin
          state_nxt = S_FIN;
          issue_nxt = 1'b0;
          rd_v_nxt  = 1'b0;
        end
      end

      S_FIN: begin
        out_item_nxt.fill_level  = LEVEL_W'(used_r);
        out_item_nxt.match_count = '0;
        out_item_nxt.status      = STAT_OK;
        if (op_r == OP_ERASE) begin
          if (scan.hit) begin
            state_nxt = S_MOVE_RD;
          end else begin
            out_item_nxt.status = STAT_NOT_FOUND;
            out_valid_nxt       = 1'b1;
            state_nxt           = S_IDLE;
          end
        end else begin
          out_item_nxt.match_count = LEVEL_W'(scan.count);
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end

      // fetch the last entry, then drop it into the freed slot
      S_MOVE_RD: begin
        raddr     = last_idx;
        state_nxt = S_MOVE_WR;
      end

      S_MOVE_WR: begin
        we                      = 1'b1;
        waddr                   = scan.hit_idx;
        wdata                   = rdata_r;
        used_nxt                = used_r - CNT_W'(1);
        out_item_nxt.status     = STAT_OK;
        out_item_nxt.fill_level = LEVEL_W'(used_nxt);
        out_valid_nxt           = 1'b1;
        state_nxt               = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      issue_r     <= 1'b0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      issue_r     <= issue_nxt;
      rd_v_r      <= rd_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    addr_r     <= addr_nxt;
    rd_idx_r   <= rd_idx_nxt;
    out_item_r <= out_item_nxt;
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire
